// ===== src/l96_pkg.sv =====
// ----------------------------------------------------------------------------
// l96_pkg
// shared types, constants and helpers of the lorenz-96 rk4 integrator
// ----------------------------------------------------------------------------
package l96_pkg;

  localparam int RING_SIZE = 40;
  localparam int IDX_W     = $clog2(RING_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_SIZE - 1);

  // divide-by-six unit: quotient width and number of divide steps
  localparam int DIV_W     = 44;
  localparam int DIV_STEPS = 5;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  // 2^16 - 1 = 3 * 21845, and 43691 / 2^17 is one third for 16-bit values
  localparam logic [15:0] FOLD_MUL = 16'd21845;
  localparam logic [15:0] RECIP3   = 16'd43691;

  localparam int ACC_W = 35;

  // configuration register indexes
  localparam logic [1:0] CFG_FORCING    = 2'd0;
  localparam logic [1:0] CFG_TIME_STEP  = 2'd1;
  localparam logic [1:0] CFG_STEP_COUNT = 2'd2;

  localparam logic signed [31:0] FORCING_RST    = 32'sd8388608;
  localparam logic [30:0]        TIME_STEP_RST  = 31'd52429;
  localparam logic [15:0]        STEP_COUNT_RST = 16'd200;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FILL,
    OP_RD_P1,
    OP_RD_M2,
    OP_RD_M1,
    OP_RD_0,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SLOPE,
    OP_SUM,
    OP_DT_LO,
    OP_DT_HI,
    OP_STAGE_WR,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_BASE_WR,
    OP_EMIT
  } l96_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD_P1,
    ST_RD_M2,
    ST_RD_M1,
    ST_RD_0,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SLOPE,
    ST_SUM,
    ST_DT_LO,
    ST_DT_HI,
    ST_STAGE_WR,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_BASE_WR,
    ST_EMIT
  } l96_state_t;

  typedef struct packed {
    l96_op_t          op;
    logic [IDX_W-1:0] idx;
    logic [1:0]       stage;
    logic             last;
  } l96_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sh0000_7FFF_FFFF;
    lo = -48'sh0000_8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // sign-magnitude to two's complement, 48 bits
  function automatic logic signed [47:0] apply_sign(input logic [DIV_W-1:0] mag,
                                                    input logic neg);
    logic signed [47:0] m;
    m = $signed(48'(mag));
    return neg ? -m : m;
  endfunction

endpackage

// ===== src/l96_ctrl.sv =====
// ----------------------------------------------------------------------------
// l96_ctrl
// sequencer: load, zero fill, rk4 stages per element, divide, emit
// ----------------------------------------------------------------------------
module l96_ctrl import l96_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        in_last,
  input  logic [15:0] step_count,
  output logic        busy,
  output l96_cmd_t    cmd
);

  l96_state_t state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [1:0]           stage_r, stage_nxt;
  logic [15:0]          steps_r, steps_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 idx_end;
  logic [16:0]          steps_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      stage_r <= '0;
      steps_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      stage_r <= stage_nxt;
      steps_r <= steps_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign idx_end   = (idx_r == LAST_IDX);
  assign steps_inc = {1'b0, steps_r} + 17'd1;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    stage_nxt = stage_r;
    steps_nxt = steps_r;
    cnt_nxt   = cnt_r;
    busy      = 1'b1;
    cmd.op    = OP_NONE;
    cmd.idx   = idx_r;
    cmd.stage = stage_r;
    cmd.last  = idx_end;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.op = OP_LOAD;
          if (idx_end) begin
            idx_nxt   = '0;
            stage_nxt = '0;
            steps_nxt = '0;
            state_nxt = (step_count == 16'd0) ? ST_EMIT : ST_RD_P1;
          end else begin
            idx_nxt = idx_r + 1'b1;
            if (in_last) state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        cmd.op = OP_FILL;
        if (idx_end) begin
          idx_nxt   = '0;
          stage_nxt = '0;
          steps_nxt = '0;
          state_nxt = (step_count == 16'd0) ? ST_EMIT : ST_RD_P1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_RD_P1: begin
        cmd.op    = OP_RD_P1;
        state_nxt = ST_RD_M2;
      end
      ST_RD_M2: begin
        cmd.op    = OP_RD_M2;
        state_nxt = ST_RD_M1;
      end
      ST_RD_M1: begin
        cmd.op    = OP_RD_M1;
        state_nxt = ST_RD_0;
      end
      ST_RD_0: begin
        cmd.op    = OP_RD_0;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.op    = OP_MUL_LO;
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.op    = OP_MUL_HI;
        state_nxt = ST_SLOPE;
      end
      ST_SLOPE: begin
        cmd.op    = OP_SLOPE;
        state_nxt = (stage_r == 2'd3) ? ST_SUM : ST_DT_LO;
      end
      ST_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = ST_DT_LO;
      end
      ST_DT_LO: begin
        cmd.op    = OP_DT_LO;
        state_nxt = ST_DT_HI;
      end
      ST_DT_HI: begin
        cmd.op    = OP_DT_HI;
        state_nxt = (stage_r == 2'd3) ? ST_DIV_LOAD : ST_STAGE_WR;
      end
      ST_STAGE_WR: begin
        cmd.op    = OP_STAGE_WR;
        state_nxt = ST_RD_P1;
        if (idx_end) begin
          idx_nxt   = '0;
          stage_nxt = stage_r + 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DIV_LOAD: begin
        cmd.op    = OP_DIV_LOAD;
        cnt_nxt   = '0;
        state_nxt = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_BASE_WR;
      end
      ST_BASE_WR: begin
        cmd.op    = OP_BASE_WR;
        state_nxt = ST_RD_P1;
        if (idx_end) begin
          idx_nxt   = '0;
          stage_nxt = '0;
          steps_nxt = steps_inc[15:0];
          if (steps_inc == {1'b0, step_count}) state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.op = OP_EMIT;
        if (idx_end) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/l96_dp.sv =====
// ----------------------------------------------------------------------------
// l96_dp
// vector memories, shared 32x16 multiplier, rounding, divide-by-six unit
// ----------------------------------------------------------------------------
module l96_dp import l96_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  l96_cmd_t           cmd,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] forcing,
  input  logic [30:0]        time_step,
  output logic               out_valid,
  output logic signed [31:0] out_result_value,
  output logic               out_result_last
);

  logic signed [31:0]      base_mem [RING_SIZE];
  logic signed [31:0]      sa_mem   [RING_SIZE];
  logic signed [31:0]      sb_mem   [RING_SIZE];
  logic signed [ACC_W-1:0] acc_mem  [RING_SIZE];

  logic signed [31:0]      base_q_r, sa_q_r, sb_q_r;
  logic signed [ACC_W-1:0] acc_q_r;

  logic signed [31:0]      xp1_r, xm2_r, xm1_r, x0_r, bi_r, k_r, s_r;
  logic signed [ACC_W-1:0] acci_r;
  logic [31:0]             dmag_r;
  logic                    dsgn_r, psgn_r;
  logic [63:0]             prod_r;
  logic [DIV_W-1:0]        dv_r;
  logic [DIV_W-1:0]        rem_r;
  logic                    out_valid_r, out_last_r;

  logic [IDX_W-1:0]        addr, p1, m1, m2;
  logic signed [31:0]      src_q;
  logic signed [32:0]      diff;
  logic [31:0]             a_op, b_full;
  logic [15:0]             b_half;
  logic [47:0]             mp;
  logic [63:0]             rnd20, rnd21, rnd_div;
  logic [DIV_W-1:0]        rs_mag;
  logic signed [31:0]      k_val, stage_val, s_val, base_val;
  logic signed [ACC_W-1:0] acc_val;
  logic [DIV_W-1:0]        dv_nxt;
  logic [DIV_W-1:0]        rem_nxt;
  logic [DIV_W-17:0]       fold_t;
  logic [31:0]             recip;
  logic                    base_we, sa_we, sb_we, acc_we;
  logic signed [31:0]      base_wd;

  // ring neighbors
  assign p1 = (cmd.idx == LAST_IDX) ? '0 : cmd.idx + 1'b1;
  assign m1 = (cmd.idx == '0) ? LAST_IDX : cmd.idx - 1'b1;
  assign m2 = (cmd.idx >= IDX_W'(2)) ? cmd.idx - IDX_W'(2)
                                     : cmd.idx + IDX_W'(RING_SIZE - 2);

  always_comb begin
    unique case (cmd.op)
      OP_RD_P1: addr = p1;
      OP_RD_M2: addr = m2;
      OP_RD_M1: addr = m1;
      default:  addr = cmd.idx;
    endcase
  end

  // stage 0 reads base, stages 1 and 3 read buffer a, stage 2 reads buffer b
  always_comb begin
    unique case (cmd.stage)
      2'd0:    src_q = base_q_r;
      2'd2:    src_q = sb_q_r;
      default: src_q = sa_q_r;
    endcase
  end

  assign diff = 33'(xp1_r) - 33'(xm2_r);

  // shared multiplier, one 16-bit half of b per cycle
  always_comb begin
    if (cmd.op == OP_MUL_LO || cmd.op == OP_MUL_HI) begin
      a_op   = dmag_r;
      b_full = abs32(xm1_r);
    end else begin
      a_op   = (cmd.stage == 2'd3) ? abs32(s_r) : abs32(k_r);
      b_full = {1'b0, time_step};
    end
    b_half = (cmd.op == OP_MUL_HI || cmd.op == OP_DT_HI) ? b_full[31:16] : b_full[15:0];
    mp     = a_op * b_half;
  end

  // rounding to nearest on the magnitude, ties away from zero
  assign rnd20   = prod_r + 64'h8_0000;
  assign rnd21   = prod_r + 64'h10_0000;
  assign rnd_div = prod_r + 64'h30_0000;
  assign rs_mag  = (cmd.stage == 2'd2) ? rnd20[63:20] : {1'b0, rnd21[63:21]};

  assign k_val     = sat32(apply_sign(rnd20[63:20], psgn_r) - 48'(x0_r) + 48'(forcing));
  assign stage_val = sat32(apply_sign(rs_mag, psgn_r) + 48'(bi_r));
  assign s_val     = sat32(48'(acci_r) + 48'(k_r));
  assign base_val  = sat32(apply_sign(dv_r, psgn_r) + 48'(bi_r));
  assign acc_val   = (cmd.stage == 2'd0) ? ACC_W'(k_r) : acci_r + (ACC_W'(k_r) <<< 1);

  // divide the halved value by three: fold the bits above 16 down
  // (2^16 is 1 mod 3), then a reciprocal multiply finishes the low 16 bits
  always_comb begin
    fold_t  = rem_r[DIV_W-1:16];
    recip   = 32'(rem_r[15:0]) * 32'(RECIP3);
    dv_nxt  = dv_r;
    rem_nxt = rem_r;
    if (fold_t != '0) begin
      dv_nxt  = dv_r + DIV_W'(fold_t) * DIV_W'(FOLD_MUL);
      rem_nxt = DIV_W'(fold_t) + DIV_W'(rem_r[15:0]);
    end else begin
      dv_nxt  = dv_r + DIV_W'(recip[31:17]);
      rem_nxt = '0;
    end
  end

  always_comb begin
    base_we = 1'b0;
    base_wd = in_value;
    sa_we   = 1'b0;
    sb_we   = 1'b0;
    acc_we  = 1'b0;
    unique case (cmd.op)
      OP_LOAD: base_we = 1'b1;
      OP_FILL: begin
        base_we = 1'b1;
        base_wd = '0;
      end
      OP_STAGE_WR: begin
        acc_we = 1'b1;
        sa_we  = (cmd.stage != 2'd1);
        sb_we  = (cmd.stage == 2'd1);
      end
      OP_BASE_WR: begin
        base_we = 1'b1;
        base_wd = base_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (base_we) base_mem[addr] <= base_wd;
    if (sa_we)   sa_mem[addr]   <= stage_val;
    if (sb_we)   sb_mem[addr]   <= stage_val;
    if (acc_we)  acc_mem[addr]  <= acc_val;
    base_q_r <= base_mem[addr];
    sa_q_r   <= sa_mem[addr];
    sb_q_r   <= sb_mem[addr];
    acc_q_r  <= acc_mem[addr];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_RD_M2: xp1_r <= src_q;
      OP_RD_M1: xm2_r <= src_q;
      OP_RD_0: begin
        xm1_r  <= src_q;
        dmag_r <= diff[32] ? 32'(-diff) : diff[31:0];
        dsgn_r <= diff[32];
      end
      OP_MUL_LO: begin
        x0_r   <= src_q;
        bi_r   <= base_q_r;
        acci_r <= acc_q_r;
        prod_r <= 64'(mp);
        psgn_r <= dsgn_r ^ xm1_r[31];
      end
      OP_MUL_HI: prod_r <= prod_r + {mp, 16'b0};
      OP_SLOPE:  k_r    <= k_val;
      OP_SUM:    s_r    <= s_val;
      OP_DT_LO: begin
        prod_r <= 64'(mp);
        psgn_r <= (cmd.stage == 2'd3) ? s_r[31] : k_r[31];
      end
      OP_DT_HI:    prod_r <= prod_r + {mp, 16'b0};
      OP_DIV_LOAD: begin
        dv_r  <= '0;
        rem_r <= {1'b0, rnd_div[63:21]};
      end
      OP_DIV_STEP: begin
        dv_r  <= dv_nxt;
        rem_r <= rem_nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_EMIT);
    end
    out_last_r <= cmd.last;
  end

  assign out_valid        = out_valid_r;
  assign out_result_last  = out_last_r;
  assign out_result_value = base_q_r;

endmodule

// ===== src/lorenz96_rk4_integrator_top.sv =====
// ----------------------------------------------------------------------------
// lorenz96_rk4_integrator_top
// lorenz-96 ring integrator, classic rk4, signed q12.20 with saturation
// ----------------------------------------------------------------------------
// Loading takes one item per cycle while busy is low; the item with in_last
// (or the 40th) closes the vector, and a short vector is zero filled at one
// element per cycle. Each rk4 step then works through every element in
// every stage, at a pace set by the one shared 32x16 multiplier, and the
// last stage also runs the divide by six for each element.
// The 40 results then leave on consecutive cycles with out_valid high for one
// cycle each; the receiver cannot stall them. busy drops with the last result.
module lorenz96_rk4_integrator_top import l96_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output logic               out_valid,
  output logic signed [31:0] out_result_value,
  output logic               out_result_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic signed [31:0] forcing_r;
  logic [30:0]        time_step_r;
  logic [15:0]        step_count_r;
  l96_cmd_t           cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      forcing_r    <= FORCING_RST;
      time_step_r  <= TIME_STEP_RST;
      step_count_r <= STEP_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FORCING:    forcing_r    <= $signed(cfg_data);
        CFG_TIME_STEP:  time_step_r  <= cfg_data[30:0];
        CFG_STEP_COUNT: step_count_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  l96_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_last    (in_last),
    .step_count (step_count_r),
    .busy       (busy),
    .cmd        (cmd)
  );

  l96_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_value),
    .forcing          (forcing_r),
    .time_step        (time_step_r),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_result_last  (out_result_last)
  );

endmodule

// ===== src/l96_chk.sv =====
// ----------------------------------------------------------------------------
// l96_chk
// port-level checks of the result burst and busy
// ----------------------------------------------------------------------------
module l96_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_result_last
);

  // results come as one unbroken burst
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_last |=> out_valid)
    else $error("result burst broken");

  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_last |=> !out_valid)
    else $error("result after last item");

  a_busy_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_last |-> busy)
    else $error("idle during result burst");

  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_result_last)
    else $error("busy dropped without last result");

  // an idle block with no item offered stays idle
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !start |=> !busy)
    else $error("busy without an accepted item");

endmodule

bind lorenz96_rk4_integrator_top l96_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_result_last (out_result_last)
);

// ===== sim/tb_lorenz96_rk4_integrator_top.sv =====
// ----------------------------------------------------------------------------
// tb_lorenz96_rk4_integrator_top
// self-checking bench: loads state vectors, predicts the rk4 result in
// fixed point and compares every emitted element in order
// ----------------------------------------------------------------------------
module tb_lorenz96_rk4_integrator_top;
  import l96_pkg::*;

  class rk4_scoreboard;
    int signed        forcing_q;
    longint           dt_q;
    int unsigned      step_total;
    int signed        ring[RING_SIZE];
    int               load_pos;
    int signed        pending_value[$];
    bit               pending_last[$];
    int               errors;

    function new();
      forcing_q  = FORCING_RST;
      dt_q       = TIME_STEP_RST;
      step_total = STEP_COUNT_RST;
      load_pos   = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_FORCING:    forcing_q = data;
        CFG_TIME_STEP:  dt_q = longint'(data[30:0]);
        CFG_STEP_COUNT: step_total = data[15:0];
        default: ;
      endcase
    endfunction

    function int signed clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
    endfunction

    // rounded division, ties away from zero
    function longint round_div(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
    endfunction

    function int signed deriv(int signed x[RING_SIZE], int i);
      longint diff;
      diff = longint'(x[(i + 1) % RING_SIZE]) - longint'(x[(i + RING_SIZE - 2) % RING_SIZE]);
      return clip32(round_div(diff * longint'(x[(i + RING_SIZE - 1) % RING_SIZE]), 64'd1 << 20)
                    - longint'(x[i]) + longint'(forcing_q));
    endfunction

    function void rk4_advance();
      int signed k[RING_SIZE];
      int signed mid[RING_SIZE];
      int signed src[RING_SIZE];
      longint    acc[RING_SIZE];
      for (int s = 0; s < 4; s++) begin
        if (s == 0) src = ring;
        else src = mid;
        for (int i = 0; i < RING_SIZE; i++)
          k[i] = deriv(src, i);
        for (int i = 0; i < RING_SIZE; i++) begin
          if (s == 0) acc[i] = k[i];
          else acc[i] += ((s == 1 || s == 2) ? 2 : 1) * longint'(k[i]);
          if (s < 2)
            mid[i] = clip32(longint'(ring[i]) + round_div(dt_q * k[i], 64'd1 << 21));
          else if (s == 2)
            mid[i] = clip32(longint'(ring[i]) + round_div(dt_q * k[i], 64'd1 << 20));
        end
      end
      for (int i = 0; i < RING_SIZE; i++)
        ring[i] = clip32(longint'(ring[i]) + round_div(dt_q * clip32(acc[i]), 64'd6 << 20));
    endfunction

    function void note_item(int signed v, bit l);
      ring[load_pos] = v;
      load_pos++;
      if (!l && load_pos < RING_SIZE) return;
      for (int i = load_pos; i < RING_SIZE; i++) ring[i] = 0;
      load_pos = 0;
      for (int n = 0; n < step_total; n++) rk4_advance();
      for (int i = 0; i < RING_SIZE; i++) begin
        pending_value.push_back(ring[i]);
        pending_last.push_back(i == RING_SIZE - 1);
      end
    endfunction

    function void check_result(int signed v, bit l);
      int signed ev;
      bit        el;
      if (pending_value.size() == 0) begin
        if (errors < 10) $display("unexpected result value=%0d last=%0b", v, l);
        errors++;
        return;
      end
      ev = pending_value.pop_front();
      el = pending_last.pop_front();
      if (ev !== v || el !== l) begin
        if (errors < 10)
          $display("mismatch: expected value=%0d last=%0b, got value=%0d last=%0b",
                   ev, el, v, l);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_value;
  logic               in_last;
  logic               out_valid;
  logic signed [31:0] out_result_value;
  logic               out_result_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;

  rk4_scoreboard sb = new();
  int idle_pct = 8;
  int items_sent = 0;

  lorenz96_rk4_integrator_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_value(in_value), .in_last(in_last),
    .out_valid(out_valid), .out_result_value(out_result_value),
    .out_result_last(out_result_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("tb_lorenz96_rk4_integrator_top: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_result_value, out_result_last);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic signed [31:0] v, input logic l);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    in_last  <= l;
    do begin
      @(posedge clk);
      taken = !busy;
      if (taken) sb.note_item(v, l);
      @(negedge clk);
    end while (!taken);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block goes quiet once every element has come out and busy is low
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending_value.size() != 0 || busy) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(3) == 0) return $urandom;
    return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
  endfunction

  task automatic send_vector(input int len, input bit marked);
    for (int i = 0; i < len; i++)
      send_item(pick_value(), marked && (i == len - 1));
  endtask

  initial begin
    int len;
    bit marked;
    start     = 1'b0;
    in_value  = '0;
    in_last   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FORCING;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero steps: extremes come back unchanged
    write_reg(CFG_STEP_COUNT, 32'd65535);
    write_reg(CFG_STEP_COUNT, 32'd0);
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sh5555_AAAA, 1'b1);
    wait_drained();

    // saturating settings, single-element and short vectors
    write_reg(CFG_STEP_COUNT, 32'd1);
    write_reg(CFG_FORCING, 32'h8000_0000);
    write_reg(CFG_TIME_STEP, 32'h7FFF_FFFF);
    send_item(32'sh7FFF_FFFF, 1'b1);
    wait_drained();
    write_reg(CFG_FORCING, 32'h7FFF_FFFF);
    write_reg(CFG_TIME_STEP, 32'd0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh0080_0000, 1'b0);
    send_item(-32'sh0123_4567, 1'b1);
    wait_drained();

    write_reg(CFG_FORCING, 32'd8388608);
    write_reg(CFG_TIME_STEP, 32'd52429);
    write_reg(CFG_STEP_COUNT, 32'd2);

    while (items_sent < 110) begin
      if (items_sent > 90) idle_pct = 0;
      else if (items_sent > 50) idle_pct = 59;
      else idle_pct = 8;
      marked = 1'b1;
      case ($urandom_range(3))
        0: begin
          len    = RING_SIZE; // unmarked: 40th element closes it
          marked = 1'b0;
        end
        1: len = RING_SIZE;
        default: len = $urandom_range(1, RING_SIZE);
      endcase
      if (len > 110 - items_sent) begin
        len    = 110 - items_sent;
        marked = 1'b1;
      end
      send_vector(len, marked);
      wait_drained();
      if ($urandom_range(1)) write_reg(CFG_FORCING, $urandom_range(32'h0100_0000));
      if ($urandom_range(1)) write_reg(CFG_TIME_STEP, $urandom_range(32'd200_000));
      write_reg(CFG_STEP_COUNT, $urandom_range(3));
    end
    wait_drained();

    if (sb.errors == 0 && sb.pending_value.size() == 0) begin
      $display("tb_lorenz96_rk4_integrator_top: PASS");
    end else begin
      $display("tb_lorenz96_rk4_integrator_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/l96_pkg.sv
src/l96_ctrl.sv
src/l96_dp.sv
src/lorenz96_rk4_integrator_top.sv
src/l96_chk.sv
sim/tb_lorenz96_rk4_integrator_top.sv
